// ----- src/ale_pkg.sv -----
`default_nettype none

package ale_pkg;

  // list store geometry
  localparam int DEPTH  = 256;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = AW + 1;
  // compare width: wide enough for any count and any non-negative position
  localparam int CMPW   = (CW > 10) ? CW : 10;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [8:0] CAP_RESET = 9'd256;
  localparam logic [8:0] NO_INDEX  = 9'h1FF;

  // internal operation classes
  localparam logic [2:0] OP_LOCATE     = 3'd0;
  localparam logic [2:0] OP_INS_BEFORE = 3'd1;
  localparam logic [2:0] OP_INS_AFTER  = 3'd2;
  localparam logic [2:0] OP_DEL_AT     = 3'd3;
  localparam logic [2:0] OP_DEL_ALL    = 3'd4;
  localparam logic [2:0] OP_NOP        = 3'd5;

  // command codes on the input port
  localparam logic [2:0] CMD_LOCATE     = 3'd0;
  localparam logic [2:0] CMD_INS_BEFORE = 3'd1;
  localparam logic [2:0] CMD_INS_AFTER  = 3'd2;
  localparam logic [2:0] CMD_DEL_AT     = 3'd3;
  localparam logic [2:0] CMD_DEL_ALL    = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_APPEND   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_ILLEGAL  = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  // classified command word
  typedef struct packed {
    logic [2:0]      op;
    logic            neg;
    logic [CMPW-1:0] posx;
    logic [31:0]     value;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/array_list_engine_top.sv -----
// Channel | Ports                                          | Handshake
// --------+------------------------------------------------+-----------------------
// in      | in_command, in_position, in_value              | in_push / in_full
// out     | out_status, out_found_index, out_count,        | out_pop / out_empty
//         | out_empty_res                                  |
// cfg     | cfg_data (capacity)                            | cfg_valid / cfg_ready
//
// Each word is dispatched, then the store is walked one entry per cycle through its
// single read port: locate walks from the front until a match, delete all equal walks
// all n entries in use, insert walks the tail down to the insert point, and delete at p
// walks the entries after p. Rejected and unused commands finish at dispatch, unwalked.
// Reset clears control state; the store is not cleared.
// A two-word command queue takes input while the back end works; the back end starts
// a word only once the result register is empty.
`default_nettype none

module array_list_engine_top
  import ale_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [2:0]         in_command,
  input  wire logic signed [9:0]  in_position,
  input  wire logic signed [31:0] in_value,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [2:0]              out_status,
  output logic signed [8:0]       out_found_index,
  output logic [8:0]              out_count,
  output logic                    out_empty_res,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [8:0]         cfg_data
);

  logic       q_valid;
  cmd_t       q_head;
  logic       q_pop;
  logic       res_valid;
  logic [8:0] res_index;

  // capacity writes are always taken
  assign cfg_ready = 1'b1;

  ale_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_command  (in_command),
    .in_position (in_position),
    .in_value    (in_value),
    .in_full     (in_full),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop)
  );

  ale_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .res_pop    (out_pop),
    .res_valid  (res_valid),
    .res_status (out_status),
    .res_index  (res_index),
    .res_count  (out_count),
    .res_empty  (out_empty_res)
  );

  assign out_empty       = !res_valid;
  assign out_found_index = res_index;

endmodule

`default_nettype wire

// ----- src/ale_ram.sv -----
`default_nettype none

module ale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/ale_front.sv -----
`default_nettype none

module ale_front
  import ale_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  input  wire logic [2:0]         in_command,
  input  wire logic signed [9:0]  in_position,
  input  wire logic signed [31:0] in_value,
  output logic                    in_full,
  output logic                    q_valid,
  output cmd_t                    q_head,
  input  wire logic               q_pop
);

  cmd_t           q_mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   n_r, n_nxt;
  cmd_t           cls;
  logic           push_ok;
  logic           pop_ok;

  // classify the incoming word
  always_comb begin
    cls.neg   = in_position[9];
    cls.posx  = CMPW'(in_position[8:0]);
    cls.value = in_value;
    unique case (in_command)
      CMD_LOCATE:     cls.op = OP_LOCATE;
      CMD_INS_BEFORE: cls.op = OP_INS_BEFORE;
      CMD_INS_AFTER:  cls.op = OP_INS_AFTER;
      CMD_DEL_AT:     cls.op = OP_DEL_AT;
      CMD_DEL_ALL:    cls.op = OP_DEL_ALL;
      default:        cls.op = OP_NOP;
    endcase
  end

  assign in_full = (n_r == (QAW+1)'(QDEPTH));
  assign q_valid = (n_r != '0);
  assign q_head  = q_mem_r[rp_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && q_valid;

  // queue pointers
  always_comb begin
    wp_nxt = push_ok ? wp_r + 1'b1 : wp_r;
    rp_nxt = pop_ok  ? rp_r + 1'b1 : rp_r;
    n_nxt  = n_r;
    if (push_ok && !pop_ok) begin
      n_nxt = n_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      n_nxt = n_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      n_r  <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      n_r  <= n_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem_r[wp_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// ----- src/ale_back.sv -----
`default_nettype none

module ale_back
  import ale_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_data,
  input  wire logic       q_valid,
  input  wire cmd_t       q_head,
  output logic            q_pop,
  input  wire logic       res_pop,
  output logic            res_valid,
  output logic [2:0]      res_status,
  output logic [8:0]      res_index,
  output logic [8:0]      res_count,
  output logic            res_empty
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic          state_r, state_nxt;
  logic [8:0]    cap_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [AW-1:0] at_r, at_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [AW-1:0] ri_r, ri_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          pv_r, pv_nxt;
  logic [AW-1:0] pi_r, pi_nxt;
  logic [CW-1:0] w_r, w_nxt;

  logic          res_valid_r, res_valid_nxt;
  logic [2:0]    res_status_r, res_status_nxt;
  logic [8:0]    res_index_r, res_index_nxt;
  logic [8:0]    res_count_r, res_count_nxt;
  logic          res_empty_r, res_empty_nxt;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [31:0]   rdata;

  logic [CMPW-1:0] cap_x, lim, cnt_x;

  // entry store
  ale_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ri_r),
    .rdata (rdata)
  );

  // limit in force is min(capacity, depth)
  assign cap_x = CMPW'(cap_r);
  assign lim   = (cap_x > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_x;
  assign cnt_x = CMPW'(cnt_r);

  // dispatch and walk
  always_comb begin
    logic            fin;
    logic [2:0]      fin_st;
    logic [8:0]      fin_idx;
    logic [CW-1:0]   fin_cnt;
    logic [CMPW-1:0] at_w;
    logic            issue;
    logic            match;
    logic            done;

    fin     = 1'b0;
    fin_st  = ST_OK;
    fin_idx = NO_INDEX;
    fin_cnt = cnt_r;
    at_w    = '0;
    issue   = (rem_r != '0);
    match   = (rdata == val_r);
    done    = !issue && !pv_r;

    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    at_nxt    = at_r;
    st_nxt    = st_r;
    ri_nxt    = ri_r;
    rem_nxt   = rem_r;
    pv_nxt    = pv_r;
    pi_nxt    = pi_r;
    w_nxt     = w_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = rdata;

    res_valid_nxt  = res_valid_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_count_nxt  = res_count_r;
    res_empty_nxt  = res_empty_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && !res_valid_r) begin
          q_pop   = 1'b1;
          op_nxt  = q_head.op;
          val_nxt = q_head.value;
          pv_nxt  = 1'b0;
          w_nxt   = '0;
          unique case (q_head.op)
            OP_LOCATE: begin
              ri_nxt    = '0;
              rem_nxt   = cnt_r;
              state_nxt = S_SCAN;
            end
            OP_INS_BEFORE, OP_INS_AFTER: begin
              if (cnt_x >= lim) begin
                fin    = 1'b1;
                fin_st = ST_FULL;
              end else if (q_head.neg || q_head.posx >= lim) begin
                fin    = 1'b1;
                fin_st = ST_ILLEGAL;
              end else begin
                if (q_head.posx < cnt_x) begin
                  at_w   = (q_head.op == OP_INS_BEFORE) ? q_head.posx : q_head.posx + 1'b1;
                  st_nxt = ST_OK;
                end else begin
                  at_w   = cnt_x;
                  st_nxt = ST_APPEND;
                end
                at_nxt    = AW'(at_w);
                rem_nxt   = CW'(cnt_x - at_w);
                ri_nxt    = AW'(cnt_r - 1'b1);
                state_nxt = S_SCAN;
              end
            end
            OP_DEL_AT: begin
              if (cnt_r == '0) begin
                fin    = 1'b1;
                fin_st = ST_EMPTY;
              end else if (q_head.neg || q_head.posx >= cnt_x) begin
                fin    = 1'b1;
                fin_st = ST_ILLEGAL;
              end else begin
                ri_nxt    = AW'(q_head.posx + 1'b1);
                rem_nxt   = CW'(cnt_x - q_head.posx - 1'b1);
                state_nxt = S_SCAN;
              end
            end
            OP_DEL_ALL: begin
              if (cnt_r == '0) begin
                fin    = 1'b1;
                fin_st = ST_EMPTY;
              end else begin
                ri_nxt    = '0;
                rem_nxt   = cnt_r;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // one read issued per cycle while entries remain, data lands in the following cycle
        pv_nxt = issue;
        pi_nxt = ri_r;
        if (issue) begin
          rem_nxt = rem_r - 1'b1;
          if (op_r == OP_INS_BEFORE || op_r == OP_INS_AFTER) begin
            ri_nxt = ri_r - 1'b1;
          end else begin
            ri_nxt = ri_r + 1'b1;
          end
        end
        unique case (op_r)
          OP_LOCATE: begin
            if (pv_r && match) begin
              fin     = 1'b1;
              fin_idx = 9'(pi_r);
            end else if (done) begin
              fin    = 1'b1;
              fin_st = ST_NOTFOUND;
            end
          end
          OP_INS_BEFORE, OP_INS_AFTER: begin
            // shift tail up, then drop the new word in the gap
            if (pv_r) begin
              we    = 1'b1;
              waddr = pi_r + 1'b1;
            end
            if (done) begin
              we      = 1'b1;
              waddr   = at_r;
              wdata   = val_r;
              fin     = 1'b1;
              fin_st  = st_r;
              fin_idx = 9'(at_r);
              fin_cnt = cnt_r + 1'b1;
            end
          end
          OP_DEL_AT: begin
            // shift tail down over the removed entry
            if (pv_r) begin
              we    = 1'b1;
              waddr = pi_r - 1'b1;
            end
            if (done) begin
              fin     = 1'b1;
              fin_cnt = cnt_r - 1'b1;
            end
          end
          OP_DEL_ALL: begin
            // compact the survivors in order
            if (pv_r && !match) begin
              we    = 1'b1;
              waddr = w_r[AW-1:0];
              w_nxt = w_r + 1'b1;
            end
            if (done) begin
              fin     = 1'b1;
              fin_cnt = w_r;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result register
    if (res_pop && res_valid_r) begin
      res_valid_nxt = 1'b0;
    end
    if (fin) begin
      state_nxt      = S_IDLE;
      cnt_nxt        = fin_cnt;
      res_valid_nxt  = 1'b1;
      res_status_nxt = fin_st;
      res_index_nxt  = fin_idx;
      res_count_nxt  = 9'(fin_cnt);
      res_empty_nxt  = (fin_cnt == '0);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cap_r       <= CAP_RESET;
      pv_r        <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      res_valid_r <= res_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    at_r         <= at_nxt;
    st_r         <= st_nxt;
    ri_r         <= ri_nxt;
    rem_r        <= rem_nxt;
    pi_r         <= pi_nxt;
    w_r          <= w_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_count_r  <= res_count_nxt;
    res_empty_r  <= res_empty_nxt;
  end

  assign res_valid  = res_valid_r;
  assign res_status = res_status_r;
  assign res_index  = res_index_r;
  assign res_count  = res_count_r;
  assign res_empty  = res_empty_r;

endmodule

`default_nettype wire
